[rtl/irc_message_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// IRC tokenizer assertion macros
// Same-cycle and next-cycle implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef IRC_MESSAGE_TOKENIZER_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IRC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("irc tokenizer check failed");

// antecedent implies consequent in the next cycle
`define IRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("irc tokenizer check failed");

`endif

[rtl/irc_tok_pkg.sv]
// ----------------------------------------------------------------------------
// IRC tokenizer package
// Token kinds, parse phases, result bundles and shared constants.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    localparam int MAX_RES         = 5;
    localparam int CNT_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_DIG0  = 8'h30;
    localparam logic [7:0] C_DIG9  = 8'h39;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LOW_A = 8'h61;
    localparam logic [7:0] C_LOW_Z = 8'h7A;
    localparam logic [7:0] C_CASE  = 8'h20;

    typedef enum logic [2:0] {
        K_PREFIX = 3'd0,
        K_WORD   = 3'd1,
        K_NUMBER = 3'd2,
        K_SPACE  = 3'd3,
        K_PARAM  = 3'd4,
        K_COMMA  = 3'd5,
        K_TRAIL  = 3'd6,
        K_CRLF   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_PREFIX    = 3'd1,
        PH_PRESPACE  = 3'd2,
        PH_CMD       = 3'd3,
        PH_LEADSPACE = 3'd4,
        PH_SPACE     = 3'd5,
        PH_PARAM     = 3'd6,
        PH_TRAIL     = 3'd7
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       valid;
        logic       tend;
        logic       mend;
        logic       last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] slots;
        logic [CNT_W-1:0]      cnt;
    } t_bundle;

    typedef struct packed {
        t_phase phase;
        logic   pending_cr;
        logic   all_digits;
        logic   comma_seen;
        logic   token_open;
        logic   message_started;
    } t_tok_state;

    typedef struct packed {
        t_tok_state st;
        t_bundle    bun;
    } t_work;

    function automatic logic f_is_digit(logic [7:0] ch);
        return (ch >= C_DIG0) && (ch <= C_DIG9);
    endfunction

    function automatic logic f_is_ws(logic [7:0] ch);
        return (ch == C_SPACE) || (ch == C_TAB) || (ch == C_LF) ||
               (ch == C_VT) || (ch == C_FF) || (ch == C_CR);
    endfunction

    function automatic logic [7:0] f_upper(logic [7:0] ch);
        return ((ch >= C_LOW_A) && (ch <= C_LOW_Z)) ? ch - C_CASE : ch;
    endfunction

endpackage

[rtl/irc_message_tokenizer.sv]
// Results: an accepted byte's results are written to the queue, then loaded one by one into the output register.
// Throughput: one byte per cycle in while not full; one result per cycle out while results are popped.
// A byte's results hold the queue head until its last is loaded; QUEUE_DEPTH bundles buffer bursts.
// Reset: synchronous, active low; clears parse state, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
// IRC message tokenizer
// Splits a byte stream into messages at CR LF or packet end and emits IRC token results.
// ----------------------------------------------------------------------------
`include "irc_message_tokenizer_macros.svh"

module irc_message_tokenizer import irc_tok_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_packet,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_value_byte,
    output logic       o_value_valid,
    output logic       o_token_end,
    output logic       o_message_end,
    output logic       o_last_of_run
);

    localparam int BW = $bits(t_bundle);

    logic          accept;
    logic          f_push;
    t_bundle       f_bundle;
    logic [BW-1:0] q_head;
    logic          q_empty;
    logic          q_pop;
    logic          out_valid;
    t_result       out_res;

    assign accept = push && !full;

    irc_tok_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_push          (f_push),
        .o_bundle        (f_bundle)
    );

    irc_tok_queue #(
        .W     (BW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (f_push),
        .i_wr_data (f_bundle),
        .i_rd      (q_pop),
        .o_rd_data (q_head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    irc_tok_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (t_bundle'(q_head)),
        .i_head_empty (q_empty),
        .o_head_pop   (q_pop),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_res        (out_res)
    );

    assign empty         = !out_valid;
    assign o_token_kind  = out_res.kind;
    assign o_value_byte  = out_res.value;
    assign o_value_valid = out_res.valid;
    assign o_token_end   = out_res.tend;
    assign o_message_end = out_res.mend;
    assign o_last_of_run = out_res.last;

    `IRC_ASSERT_IMPL(a_crlf_shape, !empty && o_message_end, (o_token_kind == K_CRLF) && !o_value_valid && o_token_end && o_last_of_run)
    `IRC_ASSERT_IMPL(a_novalue_zero, !empty && !o_value_valid, (o_value_byte == 8'h00) && o_token_end)
    `IRC_ASSERT_IMPL(a_space_shape, !empty && (o_token_kind == K_SPACE), (o_value_byte == C_SPACE) && o_value_valid && o_token_end)
    `IRC_ASSERT_NEXT(a_hold_unpopped, !empty && !pop, !empty && $stable(o_token_kind) && $stable(o_value_byte))

endmodule

[rtl/irc_tok_front.sv]
// ----------------------------------------------------------------------------
// IRC tokenizer front end
// Classifies each accepted byte, updates the parse state and builds the
// bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module irc_tok_front import irc_tok_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_packet,
    output logic       o_push,
    output t_bundle    o_bundle
);

    t_tok_state r_state;
    t_tok_state n_state;

    function automatic t_work f_emit(t_work w, t_kind k, logic [7:0] ch, logic v,
                                     logic te, logic me);
        t_result r;
        r.kind  = k;
        r.value = v ? ch : 8'h00;
        r.valid = v;
        r.tend  = te;
        r.mend  = me;
        r.last  = 1'b0;
        if (w.bun.cnt < CNT_W'(MAX_RES)) begin
            w.bun.slots[w.bun.cnt] = r;
            w.bun.cnt = w.bun.cnt + 1'b1;
        end
        return w;
    endfunction

    function automatic t_work f_close(t_work w, t_kind k);
        w = f_emit(w, k, 8'h00, 1'b0, 1'b1, 1'b0);
        w.st.token_open = 1'b0;
        return w;
    endfunction

    function automatic t_work f_space(t_work w);
        return f_emit(w, K_SPACE, C_SPACE, 1'b1, 1'b1, 1'b0);
    endfunction

    function automatic t_work f_start_param(t_work w, logic [7:0] ch);
        w.st.token_open = 1'b1;
        if (ch == C_COLON) begin
            w.st.phase = PH_TRAIL;
        end else begin
            w.st.phase = PH_PARAM;
            w.st.comma_seen = (ch == C_COMMA);
            w = f_emit(w, w.st.comma_seen ? K_COMMA : K_PARAM, ch, 1'b1, 1'b0, 1'b0);
        end
        return w;
    endfunction

    function automatic t_work f_start_cmd(t_work w, logic [7:0] ch);
        if (ch == C_SPACE) begin
            w = f_space(w);
            w.st.phase = PH_LEADSPACE;
        end else if (f_is_ws(ch)) begin
            w = f_start_param(w, ch);
        end else begin
            w.st.phase = PH_CMD;
            w.st.token_open = 1'b1;
            w.st.all_digits = f_is_digit(ch);
            w = f_emit(w, w.st.all_digits ? K_NUMBER : K_WORD, f_upper(ch),
                       1'b1, 1'b0, 1'b0);
        end
        return w;
    endfunction

    function automatic t_work f_content(t_work w, logic [7:0] ch);
        w.st.message_started = 1'b1;
        unique case (w.st.phase)
            PH_START: begin
                if (ch == C_COLON) begin
                    w.st.phase = PH_PREFIX;
                    w.st.token_open = 1'b1;
                    w = f_emit(w, K_PREFIX, ch, 1'b1, 1'b0, 1'b0);
                end else begin
                    w = f_start_cmd(w, ch);
                end
            end
            PH_PREFIX: begin
                if (ch == C_SPACE) begin
                    w = f_close(w, K_PREFIX);
                    w = f_space(w);
                    w.st.phase = PH_PRESPACE;
                end else begin
                    w = f_emit(w, K_PREFIX, ch, 1'b1, 1'b0, 1'b0);
                end
            end
            PH_PRESPACE: begin
                if (ch != C_SPACE) begin
                    w = f_start_cmd(w, ch);
                end
            end
            PH_CMD: begin
                if (ch == C_SPACE) begin
                    w = f_close(w, w.st.all_digits ? K_NUMBER : K_WORD);
                    w = f_space(w);
                    w.st.phase = PH_SPACE;
                end else begin
                    if (!f_is_digit(ch)) begin
                        w.st.all_digits = 1'b0;
                    end
                    w = f_emit(w, w.st.all_digits ? K_NUMBER : K_WORD, f_upper(ch),
                               1'b1, 1'b0, 1'b0);
                end
            end
            PH_LEADSPACE, PH_SPACE: begin
                if (ch != C_SPACE) begin
                    w = f_start_param(w, ch);
                end
            end
            PH_PARAM: begin
                if (ch == C_SPACE) begin
                    w = f_close(w, w.st.comma_seen ? K_COMMA : K_PARAM);
                    w = f_space(w);
                    w.st.phase = PH_SPACE;
                end else begin
                    if (ch == C_COMMA) begin
                        w.st.comma_seen = 1'b1;
                    end
                    w = f_emit(w, w.st.comma_seen ? K_COMMA : K_PARAM, ch,
                               1'b1, 1'b0, 1'b0);
                end
            end
            PH_TRAIL: begin
                w = f_emit(w, K_TRAIL, ch, 1'b1, 1'b0, 1'b0);
            end
        endcase
        return w;
    endfunction

    function automatic t_work f_end_msg(t_work w);
        unique case (w.st.phase)
            PH_PREFIX: w = f_close(w, K_PREFIX);
            PH_CMD:    w = f_close(w, w.st.all_digits ? K_NUMBER : K_WORD);
            PH_PARAM:  w = f_close(w, w.st.comma_seen ? K_COMMA : K_PARAM);
            PH_TRAIL:  w = f_close(w, K_TRAIL);
            PH_SPACE:  w = f_emit(w, K_PARAM, 8'h00, 1'b0, 1'b1, 1'b0);
            PH_START, PH_PRESPACE, PH_LEADSPACE: begin
            end
        endcase
        w = f_emit(w, K_CRLF, 8'h00, 1'b0, 1'b1, 1'b1);
        w.st.phase           = PH_START;
        w.st.pending_cr      = 1'b0;
        w.st.all_digits      = 1'b1;
        w.st.comma_seen      = 1'b0;
        w.st.token_open      = 1'b0;
        w.st.message_started = 1'b0;
        return w;
    endfunction

    always_comb begin
        t_work w;
        logic  consumed;
        w        = '0;
        w.st     = r_state;
        consumed = 1'b0;
        if (w.st.pending_cr) begin
            w.st.pending_cr = 1'b0;
            if (i_in_byte == C_LF) begin
                w = f_end_msg(w);
                consumed = 1'b1;
            end else begin
                w = f_content(w, C_CR);
            end
        end
        if (!consumed) begin
            if (i_in_byte == C_CR) begin
                w.st.pending_cr = 1'b1;
                w.st.message_started = 1'b1;
            end else begin
                w = f_content(w, i_in_byte);
            end
        end
        if (i_end_of_packet && w.st.message_started) begin
            if (w.st.pending_cr) begin
                w.st.pending_cr = 1'b0;
                w = f_content(w, C_CR);
            end
            w = f_end_msg(w);
        end
        if (w.bun.cnt != '0) begin
            w.bun.slots[w.bun.cnt - 1'b1].last = 1'b1;
        end
        n_state  = w.st;
        o_bundle = w.bun;
        o_push   = i_accept && (w.bun.cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_START;
            r_state.pending_cr      <= 1'b0;
            r_state.all_digits      <= 1'b1;
            r_state.comma_seen      <= 1'b0;
            r_state.token_open      <= 1'b0;
            r_state.message_started <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/irc_tok_queue.sv]
// ----------------------------------------------------------------------------
// IRC tokenizer bundle queue
// Small register queue of result bundles between front and back end.
// ----------------------------------------------------------------------------
module irc_tok_queue import irc_tok_pkg::*; #(
    parameter int W     = $bits(t_bundle),
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wr_data,
    input  logic         i_rd,
    output logic [W-1:0] o_rd_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_mem[r_rp];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/irc_tok_back.sv]
// ----------------------------------------------------------------------------
// IRC tokenizer back end
// Walks the head bundle one result per cycle into the output register, while it is empty or popped.
// ----------------------------------------------------------------------------
module irc_tok_back import irc_tok_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  logic    i_head_empty,
    output logic    o_head_pop,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_res
);

    localparam int IW = $clog2(MAX_RES);

    logic [IW-1:0] r_idx;
    logic          r_valid;
    t_result       r_res;
    t_result       slot;
    logic          load;

    assign slot       = i_head.slots[r_idx];
    assign load       = !i_head_empty && (!r_valid || i_pop);
    assign o_head_pop = load && slot.last;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= slot.last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRC message tokenizer testbench
// Drives byte streams through the push/full side and pops token results.
// A built-in token predictor follows the parse state of each message. Every
// popped result is checked field by field, in order. A directed table
// covers prefixes, commands, params, trails, lone CR, empty tokens and packet
// ends. Random well-formed messages and noise follow, with random idling.
// ----------------------------------------------------------------------------
module tb;
    import irc_tok_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       eop;
        logic       typed;
        t_kind      kind;
        logic [7:0] value;
        logic       valid;
        logic       tend;
    } stim_row_t;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       valid;
        logic       tend;
        logic       mend;
        logic       last;
    } tok_t;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push    = 1'b0;
    logic       pop     = 1'b0;
    logic       calm    = 1'b0;
    stim_row_t  cur_row = '0;
    logic       full;
    logic       empty;
    logic [2:0] o_token_kind;
    logic [7:0] o_value_byte;
    logic       o_value_valid;
    logic       o_token_end;
    logic       o_message_end;
    logic       o_last_of_run;

    tok_t       expected_tokens[$];
    tok_t       step_toks[$];
    logic [7:0] msg_bytes[$];
    int         mismatches = 0;

    // predictor parse state
    t_phase ph;
    logic   pend_cr;
    logic   digits_only;
    logic   has_comma;
    logic   tok_open;
    logic   msg_started;

    stim_row_t dir_rows [31] = '{
        '{C_COLON, 1'b0, 1'b1, K_PREFIX, C_COLON, 1'b1, 1'b0},
        '{8'h6E,   1'b0, 1'b1, K_PREFIX, 8'h6E,   1'b1, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{8'h70,   1'b0, 1'b1, K_WORD,   8'h50,   1'b1, 1'b0},
        '{8'h7A,   1'b0, 1'b1, K_WORD,   8'h5A,   1'b1, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{8'h61,   1'b0, 1'b1, K_PARAM,  8'h61,   1'b1, 1'b0},
        '{C_COMMA, 1'b0, 1'b1, K_COMMA,  C_COMMA, 1'b1, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_COLON, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{8'h00,   1'b0, 1'b1, K_TRAIL,  8'h00,   1'b1, 1'b0},
        '{8'hFF,   1'b0, 1'b1, K_TRAIL,  8'hFF,   1'b1, 1'b0},
        '{C_CR,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{8'h78,   1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_CR,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_LF,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_DIG0,  1'b0, 1'b1, K_NUMBER, C_DIG0,  1'b1, 1'b0},
        '{C_DIG9,  1'b0, 1'b1, K_NUMBER, C_DIG9,  1'b1, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_CR,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_LF,    1'b1, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_SPACE, 1'b0, 1'b1, K_SPACE,  C_SPACE, 1'b1, 1'b1},
        '{8'h71,   1'b0, 1'b1, K_PARAM,  8'h71,   1'b1, 1'b0},
        '{C_CR,    1'b1, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_TAB,   1'b0, 1'b1, K_PARAM,  C_TAB,   1'b1, 1'b0},
        '{C_SPACE, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_COLON, 1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_CR,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{C_LF,    1'b0, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0},
        '{8'h41,   1'b1, 1'b0, K_PREFIX, 8'h00,   1'b0, 1'b0}
    };

    irc_message_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (cur_row.b),
        .i_end_of_packet (cur_row.eop),
        .empty           (empty),
        .pop             (pop),
        .o_token_kind    (o_token_kind),
        .o_value_byte    (o_value_byte),
        .o_value_valid   (o_value_valid),
        .o_token_end     (o_token_end),
        .o_message_end   (o_message_end),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void add_expected(tok_t t);
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void clear_msg_state();
        ph          = PH_START;
        pend_cr     = 1'b0;
        digits_only = 1'b1;
        has_comma   = 1'b0;
        tok_open    = 1'b0;
        msg_started = 1'b0;
    endfunction

    function automatic void put_tok(t_kind k, logic [7:0] b, logic v, logic te, logic me);
        tok_t t;
        if (step_toks.size() < MAX_RES) begin
            t.kind  = k;
            t.value = v ? b : 8'h00;
            t.valid = v;
            t.tend  = te;
            t.mend  = me;
            t.last  = 1'b0;
            step_toks.insert(step_toks.size(), t);
        end
    endfunction

    function automatic logic dec_digit(logic [7:0] b);
        return (b >= C_DIG0) && (b <= C_DIG9);
    endfunction

    function automatic logic [7:0] cmd_char(logic [7:0] b);
        return (b >= C_LOW_A && b <= C_LOW_Z) ? b - C_CASE : b;
    endfunction

    function automatic t_kind cmd_kind();
        return digits_only ? K_NUMBER : K_WORD;
    endfunction

    function automatic t_kind param_kind();
        return has_comma ? K_COMMA : K_PARAM;
    endfunction

    function automatic void close_tok(t_kind k);
        put_tok(k, 8'h00, 1'b0, 1'b1, 1'b0);
        tok_open = 1'b0;
    endfunction

    function automatic void open_param(logic [7:0] b);
        tok_open = 1'b1;
        if (b == C_COLON) begin
            ph = PH_TRAIL;
        end else begin
            ph        = PH_PARAM;
            has_comma = (b == C_COMMA);
            put_tok(param_kind(), b, 1'b1, 1'b0, 1'b0);
        end
    endfunction

    function automatic void open_command(logic [7:0] b);
        if (b == C_SPACE) begin
            put_tok(K_SPACE, C_SPACE, 1'b1, 1'b1, 1'b0);
            ph = PH_LEADSPACE;
        end else if (b inside {C_TAB, C_LF, C_VT, C_FF, C_CR}) begin
            open_param(b);
        end else begin
            ph          = PH_CMD;
            tok_open    = 1'b1;
            digits_only = dec_digit(b);
            put_tok(cmd_kind(), cmd_char(b), 1'b1, 1'b0, 1'b0);
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        msg_started = 1'b1;
        case (ph)
            PH_START: begin
                if (b == C_COLON) begin
                    ph       = PH_PREFIX;
                    tok_open = 1'b1;
                    put_tok(K_PREFIX, b, 1'b1, 1'b0, 1'b0);
                end else begin
                    open_command(b);
                end
            end
            PH_PREFIX: begin
                if (b == C_SPACE) begin
                    close_tok(K_PREFIX);
                    put_tok(K_SPACE, C_SPACE, 1'b1, 1'b1, 1'b0);
                    ph = PH_PRESPACE;
                end else begin
                    put_tok(K_PREFIX, b, 1'b1, 1'b0, 1'b0);
                end
            end
            PH_PRESPACE: begin
                if (b != C_SPACE) open_command(b);
            end
            PH_CMD: begin
                if (b == C_SPACE) begin
                    close_tok(cmd_kind());
                    put_tok(K_SPACE, C_SPACE, 1'b1, 1'b1, 1'b0);
                    ph = PH_SPACE;
                end else begin
                    if (!dec_digit(b)) digits_only = 1'b0;
                    put_tok(cmd_kind(), cmd_char(b), 1'b1, 1'b0, 1'b0);
                end
            end
            PH_LEADSPACE, PH_SPACE: begin
                if (b != C_SPACE) open_param(b);
            end
            PH_PARAM: begin
                if (b == C_SPACE) begin
                    close_tok(param_kind());
                    put_tok(K_SPACE, C_SPACE, 1'b1, 1'b1, 1'b0);
                    ph = PH_SPACE;
                end else begin
                    if (b == C_COMMA) has_comma = 1'b1;
                    put_tok(param_kind(), b, 1'b1, 1'b0, 1'b0);
                end
            end
            default: begin
                put_tok(K_TRAIL, b, 1'b1, 1'b0, 1'b0);
            end
        endcase
    endfunction

    function automatic void end_msg();
        case (ph)
            PH_PREFIX: close_tok(K_PREFIX);
            PH_CMD:    close_tok(cmd_kind());
            PH_PARAM:  close_tok(param_kind());
            PH_TRAIL:  close_tok(K_TRAIL);
            PH_SPACE:  put_tok(K_PARAM, 8'h00, 1'b0, 1'b1, 1'b0);
            default: ;
        endcase
        put_tok(K_CRLF, 8'h00, 1'b0, 1'b1, 1'b1);
        clear_msg_state();
    endfunction

    function automatic void predict_tokens(logic [7:0] b, logic eop);
        logic done;
        done = 1'b0;
        step_toks.delete();
        if (pend_cr) begin
            pend_cr = 1'b0;
            if (b == C_LF) begin
                end_msg();
                done = 1'b1;
            end else begin
                take_byte(C_CR);
            end
        end
        if (!done) begin
            if (b == C_CR) begin
                pend_cr     = 1'b1;
                msg_started = 1'b1;
            end else begin
                take_byte(b);
            end
        end
        if (eop && msg_started) begin
            if (pend_cr) begin
                pend_cr = 1'b0;
                take_byte(C_CR);
            end
            end_msg();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void match_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_token();
        tok_t want;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d value %0h",
                     $time, o_token_kind, o_value_byte);
            mismatches++;
        end else begin
            want = expected_tokens.pop_front();
            match_field("token_kind",  8'(want.kind),  8'(o_token_kind));
            match_field("value_byte",  want.value,     o_value_byte);
            match_field("value_valid", 8'(want.valid), 8'(o_value_valid));
            match_field("token_end",   8'(want.tend),  8'(o_token_end));
            match_field("message_end", 8'(want.mend),  8'(o_message_end));
            match_field("last_of_run", 8'(want.last),  8'(o_last_of_run));
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_tokens(cur_row.b, cur_row.eop);
                if (cur_row.typed) begin
                    add_expected('{cur_row.kind, cur_row.value, cur_row.valid,
                                   cur_row.tend, 1'b0, 1'b1});
                end else begin
                    foreach (step_toks[i]) add_expected(step_toks[i]);
                end
            end
            if (pop && !empty) check_token();
        end
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(99) >= 13);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_row(stim_row_t row);
        while (!calm && $urandom_range(99) < 13) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        cur_row <= row;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (expected_tokens.size() != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = C_LOW_A + 8'($urandom_range(25));
        return $urandom_range(1) ? c - C_CASE : c;
    endfunction

    function automatic void build_message();
        logic num_cmd;
        msg_bytes.delete();
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
            if ($urandom_range(1)) begin
                add_byte(C_CR);
                add_byte(C_LF);
            end
            return;
        end
        if ($urandom_range(2) == 0) begin
            add_byte(C_COLON);
            repeat ($urandom_range(4, 1)) add_byte(rand_letter());
            repeat ($urandom_range(2, 1)) add_byte(C_SPACE);
        end
        if ($urandom_range(9) == 0) add_byte(C_SPACE);
        num_cmd = ($urandom_range(4) < 2);
        repeat ($urandom_range(5, 1)) begin
            if (num_cmd || $urandom_range(3) == 0)
                add_byte(C_DIG0 + 8'($urandom_range(9)));
            else
                add_byte(rand_letter());
        end
        repeat ($urandom_range(3)) begin
            repeat ($urandom_range(2, 1)) add_byte(C_SPACE);
            repeat ($urandom_range(5, 1)) begin
                if ($urandom_range(3) == 0) add_byte(C_COMMA);
                else add_byte(8'($urandom_range(8'h7E, 8'h21)));
            end
        end
        if ($urandom_range(2) == 0) begin
            add_byte(C_SPACE);
            add_byte(C_COLON);
            repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(7) == 0) add_byte(C_SPACE);
        if ($urandom_range(4) != 0) begin
            add_byte(C_CR);
            add_byte(C_LF);
        end
    endfunction

    initial begin
        stim_row_t row;
        int        rand_items;
        int        msg_count;
        logic      packet_end;
        rand_items = 0;
        msg_count  = 0;
        clear_msg_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) send_row(dir_rows[i]);
        hold_until_drained();
        while (rand_items < 260) begin
            if (msg_count == 8) calm <= 1'b1;
            if (msg_count == 18) calm <= 1'b0;
            if (msg_count == 24) hold_until_drained();
            build_message();
            packet_end = ($urandom_range(4) == 0) ||
                         (msg_bytes[msg_bytes.size()-1] != C_LF && $urandom_range(1));
            foreach (msg_bytes[j]) begin
                row     = '0;
                row.b   = msg_bytes[j];
                row.eop = packet_end && (j == msg_bytes.size() - 1);
                send_row(row);
                rand_items++;
            end
            msg_count++;
        end
        push <= 1'b0;
        do @(negedge i_clk); while (expected_tokens.size() != 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
